>>> rtl/rlsv_pkg.sv
`default_nettype none
package rlsv_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUOTA   = 2'd0,
		REG_MAX_LEN = 2'd1,
		REG_VERSION = 2'd2
	} reg_idx_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_EOF  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_RECORD    = 3'd0,
		ST_END_CLEAN = 3'd1,
		ST_END_BAD   = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_QUOTA     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_PAYLOAD = 5'b00010,
		PH_TRAILER = 5'b00100,
		PH_DISCARD = 5'b01000,
		PH_HALTED  = 5'b10000
	} phase_t;

	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;
	localparam logic [32:0] FRAME_OVERHEAD = 33'd20;
	localparam logic [31:0] QUOTA_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] MAX_LEN_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] VERSION_RST = 32'd1;

	localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h4C, 8'h53, 8'h31};

	typedef struct packed {
		logic [31:0] discarded_bytes;
		logic [31:0] payload_length;
		logic [31:0] prefix_bytes;
		logic [31:0] good_records;
	} out_data_t;

	typedef struct packed {
		logic    tail_cut;
		status_t status;
	} out_user_t;

endpackage
`default_nettype wire

>>> rtl/record_log_scan_validator.sv
// record log scan validator
// input stream: one word per file byte (s_tuser = 0, byte in s_tdata) and one
// end-of-file word (s_tuser = 1). output stream: one word per accepted record,
// per length or quota halt, and per end-of-file summary (none after a halt).
// configuration: cfg_we with cfg_index 0 quota, 1 max payload length, 2 version;
// write only while the block is idle.
// a word is registered on entry and its result, if any, is written to the
// output register when the scan state advances, which waits while a held
// result is not taken; m_tvalid is driven from the output register.
// throughput: one input word per cycle while no result is held; the fnv-1a
// step (one constant multiply) and the header/trailer checks each fit in the
// single stage between the entry register and the output register.
// reset: registers take their reset values, the scan starts at a record header
// with zero counts, both streams are empty.
// stall: while m_tready is low the result is held; the entry register still
// takes one more word if it is empty, and then s_tready drops until the result is taken.
`default_nettype none
module record_log_scan_validator #(
	parameter int OFFSET_BITS = rlsv_pkg::OFFSET_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [rlsv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [rlsv_pkg::CFG_W-1:0]        cfg_data,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,   // data_byte
	input  wire                               s_tuser,   // command
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [127:0]                      m_tdata,   // good_records, prefix_bytes,
	                                                     // payload_length, discarded_bytes
	output logic [3:0]                        m_tuser    // status[2:0], tail_cut
);

	localparam int W = OFFSET_BITS;
	localparam int SW = ((W > 33) ? W : 33) + 1;
	localparam logic [31:0] CNT_LIM = (W >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << W) - 64'd1);

	logic [31:0] quota_q, max_len_q, version_cfg_q;

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       advance;

	rlsv_pkg::phase_t phase_q, phase_d;
	logic [3:0]  field_q, field_d;
	logic [31:0] version_q, version_d;
	logic [31:0] decl_q, decl_d;
	logic        hi_q, hi_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] hash_q, hash_d;
	logic [31:0] trailer_q, trailer_d;
	logic [31:0] count_q, count_d;
	logic [W-1:0] prefix_q, prefix_d;
	logic [W-1:0] total_q, total_d;
	logic [W-1:0] end_q, end_d;
	logic        tail_q, tail_d;

	logic                   emit;
	rlsv_pkg::out_data_t    res_data;
	rlsv_pkg::out_user_t    res_user;
	rlsv_pkg::out_data_t    out_data_q;
	rlsv_pkg::out_user_t    out_user_q;
	logic                   out_valid_q;

	logic [31:0]   hash_mix, hash_mul;
	logic [31:0]   version_word, trailer_word;
	logic          hi_now;
	logic [32:0]   rec_len;
	logic [SW-1:0] end_full;
	logic          end_ovf;
	logic          too_long;
	logic          over_quota;
	logic [W-1:0]  diff;
	logic [31:0]   disc;
	logic          bad;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q       <= rlsv_pkg::QUOTA_RST;
			max_len_q     <= rlsv_pkg::MAX_LEN_RST;
			version_cfg_q <= rlsv_pkg::VERSION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlsv_pkg::REG_QUOTA:   quota_q       <= cfg_data;
				rlsv_pkg::REG_MAX_LEN: max_len_q     <= cfg_data;
				rlsv_pkg::REG_VERSION: version_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign hash_mix     = hash_q ^ {24'd0, byte_s1};
	assign hash_mul     = hash_mix * rlsv_pkg::HASH_PRIME;
	assign version_word = {byte_s1, version_q[31:8]};
	assign trailer_word = {byte_s1, trailer_q[31:8]};
	assign hi_now       = hi_q || (byte_s1 != 8'd0);
	assign rec_len      = {1'b0, decl_q} + rlsv_pkg::FRAME_OVERHEAD;
	assign end_full     = SW'(prefix_q) + SW'(rec_len);
	assign end_ovf      = (end_full >> W) != '0;
	assign too_long     = hi_now || (decl_q > max_len_q) ||
		((W < 32) && ((decl_q >> W) != '0));
	assign over_quota   = SW'(end_q) > SW'(quota_q);
	assign diff         = (total_q >= prefix_q) ? (total_q - prefix_q) : '0;
	assign disc         = ((W > 32) && ((diff >> 32) != '0)) ? 32'hFFFF_FFFF : 32'(diff);
	assign bad          = tail_q || (phase_q != rlsv_pkg::PH_HEADER) || (field_q != 4'd0);

	always_comb begin
		phase_d   = phase_q;
		field_d   = field_q;
		version_d = version_q;
		decl_d    = decl_q;
		hi_d      = hi_q;
		remain_d  = remain_q;
		hash_d    = hash_q;
		trailer_d = trailer_q;
		count_d   = count_q;
		prefix_d  = prefix_q;
		total_d   = total_q;
		end_d     = end_q;
		tail_d    = tail_q;
		emit      = 1'b0;
		res_user.status         = rlsv_pkg::ST_RECORD;
		res_user.tail_cut       = 1'b0;
		res_data.good_records    = count_q;
		res_data.prefix_bytes    = 32'(prefix_q);
		res_data.payload_length  = 32'd0;
		res_data.discarded_bytes = 32'd0;

		if (cmd_s1 == rlsv_pkg::CMD_EOF) begin
			if (phase_q != rlsv_pkg::PH_HALTED) begin
				emit = 1'b1;
				res_user.status = bad ? rlsv_pkg::ST_END_BAD : rlsv_pkg::ST_END_CLEAN;
				res_user.tail_cut        = bad && (disc != 32'd0);
				res_data.discarded_bytes = disc;
			end
			// rearm
			phase_d   = rlsv_pkg::PH_HEADER;
			field_d   = 4'd0;
			version_d = 32'd0;
			decl_d    = 32'd0;
			hi_d      = 1'b0;
			remain_d  = 32'd0;
			hash_d    = rlsv_pkg::HASH_BASIS;
			trailer_d = 32'd0;
			count_d   = 32'd0;
			prefix_d  = '0;
			total_d   = '0;
			tail_d    = 1'b0;
		end else if (phase_q != rlsv_pkg::PH_HALTED) begin
			if (!(&total_q)) begin
				total_d = total_q + W'(1);
			end
			unique case (phase_q)
				rlsv_pkg::PH_PAYLOAD: begin
					hash_d   = hash_mul;
					remain_d = remain_q - 32'd1;
					if (remain_q == 32'd1) begin
						field_d   = 4'd0;
						trailer_d = 32'd0;
						phase_d   = rlsv_pkg::PH_TRAILER;
					end
				end
				rlsv_pkg::PH_TRAILER: begin
					trailer_d = trailer_word;
					field_d   = {2'b00, field_q[1:0]} + 4'd1;
					if (field_q[1:0] == 2'd3) begin
						if (hash_q != trailer_word) begin
							tail_d  = 1'b1;
							phase_d = rlsv_pkg::PH_DISCARD;
						end else if (over_quota) begin
							phase_d = rlsv_pkg::PH_HALTED;
							emit    = 1'b1;
							res_user.status = rlsv_pkg::ST_QUOTA;
						end else begin
							prefix_d = end_q;
							res_data.prefix_bytes = 32'(end_q);
							emit = 1'b1;
							if (count_q >= CNT_LIM) begin
								phase_d = rlsv_pkg::PH_HALTED;
								res_user.status = rlsv_pkg::ST_QUOTA;
							end else begin
								count_d = count_q + 32'd1;
								res_data.good_records   = count_q + 32'd1;
								res_data.payload_length = decl_q;
								phase_d   = rlsv_pkg::PH_HEADER;
								field_d   = 4'd0;
								version_d = 32'd0;
								decl_d    = 32'd0;
								hi_d      = 1'b0;
								remain_d  = 32'd0;
								hash_d    = rlsv_pkg::HASH_BASIS;
								trailer_d = 32'd0;
							end
						end
					end
				end
				rlsv_pkg::PH_DISCARD: ;
				rlsv_pkg::PH_HEADER: begin
					field_d = field_q + 4'd1;
					if (field_q < 4'd4) begin
						if (byte_s1 != rlsv_pkg::MAGIC[field_q[1:0]]) begin
							tail_d  = 1'b1;
							phase_d = rlsv_pkg::PH_DISCARD;
						end
					end else if (field_q < 4'd8) begin
						version_d = version_word;
						if ((field_q == 4'd7) && (version_word != version_cfg_q)) begin
							tail_d  = 1'b1;
							phase_d = rlsv_pkg::PH_DISCARD;
						end
					end else if (field_q < 4'd12) begin
						decl_d = {byte_s1, decl_q[31:8]};
					end else begin
						hi_d = hi_now;
						if (field_q == 4'd15) begin
							if (too_long) begin
								phase_d = rlsv_pkg::PH_HALTED;
								emit    = 1'b1;
								res_user.status = rlsv_pkg::ST_TOO_LONG;
							end else if (end_ovf) begin
								phase_d = rlsv_pkg::PH_HALTED;
								emit    = 1'b1;
								res_user.status = rlsv_pkg::ST_QUOTA;
							end else begin
								end_d     = end_full[W-1:0];
								remain_d  = decl_q;
								hash_d    = rlsv_pkg::HASH_BASIS;
								field_d   = 4'd0;
								trailer_d = 32'd0;
								phase_d   = (decl_q == 32'd0) ? rlsv_pkg::PH_TRAILER :
									rlsv_pkg::PH_PAYLOAD;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rlsv_pkg::PH_HEADER;
			field_q   <= 4'd0;
			version_q <= 32'd0;
			decl_q    <= 32'd0;
			hi_q      <= 1'b0;
			remain_q  <= 32'd0;
			hash_q    <= rlsv_pkg::HASH_BASIS;
			trailer_q <= 32'd0;
			count_q   <= 32'd0;
			prefix_q  <= '0;
			total_q   <= '0;
			tail_q    <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			field_q   <= field_d;
			version_q <= version_d;
			decl_q    <= decl_d;
			hi_q      <= hi_d;
			remain_q  <= remain_d;
			hash_q    <= hash_d;
			trailer_q <= trailer_d;
			count_q   <= count_d;
			prefix_q  <= prefix_d;
			total_q   <= total_d;
			tail_q    <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			end_q <= end_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= res_data;
			out_user_q <= res_user;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
`default_nettype wire

>>> test/record_log_scan_validator_tb.sv
`timescale 1ns / 1ps
module record_log_scan_validator_tb;
	import rlsv_pkg::*;

	localparam logic [63:0] OFF_MASK = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] REC_OVERHEAD = 64'd20;
	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] MAGIC_WORD = 32'h3153_4C4D;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_WORDS = 620;

	typedef enum {FAULT_NONE, FAULT_MAGIC, FAULT_SUM} fault_t;

	typedef struct packed {
		logic        trunc;
		status_t     status;
		logic [31:0] disc;
		logic [31:0] plen;
		logic [31:0] vbytes;
		logic [31:0] count;
	} scan_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = 2'd0;
	logic [31:0]  cfg_data = 32'd0;
	logic         s_tvalid = 1'b0;
	wire          s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tuser = 1'b0;
	wire          m_tvalid;
	logic         m_tready = 1'b0;
	wire  [127:0] m_tdata;
	wire  [3:0]   m_tuser;

	record_log_scan_validator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scan state mirrored, with lengths and offsets held in 64 bits
	logic [31:0]  cfg_quota, cfg_max_len, cfg_version;
	phase_t       ph;
	logic [3:0]   fpos;
	logic [31:0]  ver_acc;
	logic [63:0]  len_acc;
	logic [63:0]  pay_left;
	logic [31:0]  hash;
	logic [31:0]  crc_acc;
	logic [31:0]  rec_cnt;
	logic [63:0]  prefix;
	logic [63:0]  total;
	logic         tail_bad;

	scan_result_t pending_reports[$];
	scan_result_t mon_want, mon_next;
	logic [7:0]   frame_q[$];
	int           mismatches = 0;
	int           live_words = 0;
	int           quiet_cycles = 0;
	bit           gaps_on = 1'b1;
	bit           stalls_on = 1'b1;
	bit           hold_request = 1'b0;

	function automatic void clear_record();
		ph = PH_HEADER;
		fpos = 4'd0;
		ver_acc = 32'd0;
		len_acc = 64'd0;
		pay_left = 64'd0;
		hash = FNV_OFFSET;
		crc_acc = 32'd0;
	endfunction

	function automatic void scan_rearm();
		clear_record();
		rec_cnt = 32'd0;
		prefix = 64'd0;
		total = 64'd0;
		tail_bad = 1'b0;
	endfunction

	function automatic void mark_bad();
		tail_bad = 1'b1;
		ph = PH_DISCARD;
	endfunction

	function automatic scan_result_t make_result(input status_t st, input logic [31:0] plen,
			input logic [31:0] disc, input logic trunc);
		scan_result_t r;
		r.status = st;
		r.count = rec_cnt;
		r.vbytes = prefix[31:0];
		r.plen = plen;
		r.disc = disc;
		r.trunc = trunc;
		return r;
	endfunction

	function automatic bit finish_header(output scan_result_t r);
		logic [63:0] span;
		r = '0;
		if (len_acc > OFF_MASK || len_acc > {32'd0, cfg_max_len}) begin
			ph = PH_HALTED;
			r = make_result(ST_TOO_LONG, 32'd0, 32'd0, 1'b0);
			return 1'b1;
		end
		span = len_acc + REC_OVERHEAD;
		if (span > OFF_MASK || span > OFF_MASK - prefix) begin
			ph = PH_HALTED;
			r = make_result(ST_QUOTA, 32'd0, 32'd0, 1'b0);
			return 1'b1;
		end
		pay_left = len_acc;
		hash = FNV_OFFSET;
		fpos = 4'd0;
		crc_acc = 32'd0;
		if (len_acc == 64'd0) ph = PH_TRAILER;
		else ph = PH_PAYLOAD;
		return 1'b0;
	endfunction

	function automatic bit finish_record(output scan_result_t r);
		logic [63:0] end_off;
		logic [31:0] plen;
		r = '0;
		end_off = prefix + len_acc + REC_OVERHEAD;
		if (hash != crc_acc) begin
			mark_bad();
			return 1'b0;
		end
		if (end_off > {32'd0, cfg_quota}) begin
			ph = PH_HALTED;
			r = make_result(ST_QUOTA, 32'd0, 32'd0, 1'b0);
			return 1'b1;
		end
		prefix = end_off;
		if (rec_cnt == 32'hFFFF_FFFF) begin
			ph = PH_HALTED;
			r = make_result(ST_QUOTA, 32'd0, 32'd0, 1'b0);
			return 1'b1;
		end
		rec_cnt = rec_cnt + 32'd1;
		plen = len_acc[31:0];
		clear_record();
		r = make_result(ST_RECORD, plen, 32'd0, 1'b0);
		return 1'b1;
	endfunction

	function automatic bit take_byte(input logic [7:0] b, output scan_result_t r);
		logic [3:0] pos;
		r = '0;
		if (ph == PH_HALTED) return 1'b0;
		live_words++;
		if (total < OFF_MASK) total = total + 64'd1;
		case (ph)
		PH_PAYLOAD: begin
			hash = (hash ^ {24'd0, b}) * FNV_PRIME;
			pay_left = pay_left - 64'd1;
			if (pay_left == 64'd0) begin
				fpos = 4'd0;
				crc_acc = 32'd0;
				ph = PH_TRAILER;
			end
		end
		PH_TRAILER: begin
			pos = {2'b00, fpos[1:0]};
			crc_acc = crc_acc | ({24'd0, b} << (8 * pos));
			fpos = pos + 4'd1;
			if (pos == 4'd3) return finish_record(r);
		end
		PH_DISCARD: ;
		default: begin
			pos = fpos;
			fpos = pos + 4'd1;
			if (pos < 4) begin
				if (b != MAGIC_WORD[8 * pos +: 8]) mark_bad();
			end else if (pos < 8) begin
				ver_acc = ver_acc | ({24'd0, b} << (8 * (pos - 4)));
				if (pos == 4'd7 && ver_acc != cfg_version) mark_bad();
			end else begin
				len_acc = len_acc | ({56'd0, b} << (8 * (pos - 8)));
				if (pos == 4'd15) return finish_header(r);
			end
		end
		endcase
		return 1'b0;
	endfunction

	function automatic bit take_eof(output scan_result_t r);
		logic        bad;
		logic [63:0] disc;
		r = '0;
		if (ph == PH_HALTED) begin
			scan_rearm();
			return 1'b0;
		end
		bad = tail_bad || ph != PH_HEADER || fpos != 4'd0;
		disc = (total >= prefix) ? total - prefix : 64'd0;
		if (disc > 64'hFFFF_FFFF) disc = 64'hFFFF_FFFF;
		if (bad) r = make_result(ST_END_BAD, 32'd0, disc[31:0], disc != 64'd0);
		else r = make_result(ST_END_CLEAN, 32'd0, disc[31:0], 1'b0);
		scan_rearm();
		return 1'b1;
	endfunction

	function automatic bit scan_step(input logic cmd, input logic [7:0] b,
			output scan_result_t r);
		if (cmd == CMD_EOF) return take_eof(r);
		return take_byte(b, r);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// result check first, then prediction of the word taken at this edge
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, actual status %0d", $time,
					m_tuser[2:0]);
			end else begin
				mon_want = pending_reports.pop_front();
				check_field("status", {29'd0, mon_want.status}, {29'd0, m_tuser[2:0]});
				check_field("good_records", mon_want.count, m_tdata[31:0]);
				check_field("prefix_bytes", mon_want.vbytes, m_tdata[63:32]);
				check_field("payload_length", mon_want.plen, m_tdata[95:64]);
				check_field("discarded_bytes", mon_want.disc, m_tdata[127:96]);
				check_field("tail_cut", {31'd0, mon_want.trunc}, {31'd0, m_tuser[3]});
			end
		end
		if (s_tvalid && s_tready) begin
			if (scan_step(s_tuser, s_tdata, mon_next)) pending_reports.push_back(mon_next);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("record_log_scan_validator test failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(input cmd_t cmd, input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_eof();
		send_word(CMD_EOF, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_record(input logic [31:0] ver, input logic [63:0] len_field,
			input int n_pay, input fault_t fault, input int cut);
		logic [31:0] sum;
		logic [7:0]  pb;
		int          i, pos;
		frame_q.delete();
		for (i = 0; i < 4; i++) frame_q.push_back(MAGIC_WORD[8 * i +: 8]);
		for (i = 0; i < 4; i++) frame_q.push_back(ver[8 * i +: 8]);
		for (i = 0; i < 8; i++) frame_q.push_back(len_field[8 * i +: 8]);
		sum = FNV_OFFSET;
		for (i = 0; i < n_pay; i++) begin
			pb = 8'($urandom_range(0, 255));
			frame_q.push_back(pb);
			sum = (sum ^ {24'd0, pb}) * FNV_PRIME;
		end
		if (fault == FAULT_SUM) sum = sum ^ (32'd1 << $urandom_range(0, 31));
		for (i = 0; i < 4; i++) frame_q.push_back(sum[8 * i +: 8]);
		if (fault == FAULT_MAGIC) begin
			pos = $urandom_range(0, 3);
			frame_q[pos] = frame_q[pos] ^ (8'd1 << $urandom_range(0, 7));
		end
		if (cut < 0 || cut > frame_q.size()) cut = frame_q.size();
		for (i = 0; i < cut; i++) send_word(CMD_BYTE, frame_q[i]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] quota, input logic [31:0] max_len,
			input logic [31:0] ver);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_QUOTA;
		cfg_data <= quota;
		@(posedge clk);
		cfg_index <= REG_MAX_LEN;
		cfg_data <= max_len;
		@(posedge clk);
		cfg_index <= REG_VERSION;
		cfg_data <= ver;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_quota = quota;
		cfg_max_len = max_len;
		cfg_version = ver;
	endtask

	task automatic test_clean_file();
		send_eof();
		send_record(32'd1, 64'd0, 0, FAULT_NONE, -1);
		send_record(32'd1, 64'd1, 1, FAULT_NONE, -1);
		send_record(32'd1, 64'd5, 5, FAULT_NONE, -1);
		send_eof();
		// largest length that still fits, then cut right after the header
		send_record(32'd1, 64'hFFFF_FFEB, 0, FAULT_NONE, 16);
		send_eof();
	endtask

	task automatic test_bad_tail();
		send_record(32'd1, 64'd2, 2, FAULT_MAGIC, -1);
		send_eof();
		send_record(32'd1, 64'd3, 3, FAULT_NONE, -1);
		send_record(32'd2, 64'd3, 3, FAULT_NONE, -1);
		send_eof();
		send_record(32'd1, 64'd4, 4, FAULT_NONE, -1);
		send_record(32'd1, 64'd4, 4, FAULT_SUM, -1);
		send_record(32'd1, 64'd1, 1, FAULT_NONE, -1);
		send_eof();
		send_record(32'd1, 64'd2, 2, FAULT_NONE, 7);
		send_eof();
		send_record(32'd1, 64'd6, 6, FAULT_NONE, 19);
		send_eof();
		send_record(32'd1, 64'd2, 2, FAULT_NONE, 20);
		send_eof();
	endtask

	task automatic test_halts();
		int i;
		send_record(32'd1, 64'h0000_0001_0000_0000, 0, FAULT_NONE, 16);
		for (i = 0; i < 5; i++) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
		send_eof();
		send_record(32'd1, 64'd2, 2, FAULT_NONE, -1);
		send_eof();
		send_record(32'd1, 64'd0, 0, FAULT_NONE, -1);
		send_record(32'd1, 64'hFFFF_FFEB, 0, FAULT_NONE, 16);
		send_eof();
		send_record(32'd1, 64'hFFFF_FFF0, 0, FAULT_NONE, 16);
		send_eof();
	endtask

	task automatic test_register_extremes();
		set_config(32'd20, 32'd1, 32'd0);
		send_record(32'd0, 64'd0, 0, FAULT_NONE, -1);
		send_record(32'd0, 64'd0, 0, FAULT_NONE, -1);
		send_eof();
		send_record(32'd0, 64'd1, 1, FAULT_NONE, -1);
		send_eof();
		send_record(32'd0, 64'd2, 2, FAULT_NONE, 16);
		send_eof();
		send_record(32'd1, 64'd0, 0, FAULT_NONE, -1);
		send_eof();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_record(32'hFFFF_FFFF, 64'd3, 3, FAULT_NONE, -1);
		send_eof();
		send_record(32'hFFFF_FFFF, 64'hFFFF_FFFF, 0, FAULT_NONE, 16);
		send_eof();
	endtask

	task automatic test_backpressure();
		int i;
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		hold_request = 1'b1;
		for (i = 0; i < 6; i++) send_record(32'd1, 64'd0, 0, FAULT_NONE, -1);
		send_eof();
		drain();
	endtask

	task automatic random_config();
		logic [31:0] q, m, v;
		case ($urandom_range(0, 3))
		0: q = 32'd20;
		1: q = $urandom_range(20, 200);
		2: q = $urandom_range(200, 4000);
		default: q = 32'hFFFF_FFFF;
		endcase
		case ($urandom_range(0, 3))
		0: m = 32'd1;
		1: m = $urandom_range(1, 16);
		2: m = $urandom_range(16, 200);
		default: m = 32'hFFFF_FFFF;
		endcase
		case ($urandom_range(0, 3))
		0: v = 32'd0;
		1: v = 32'hFFFF_FFFF;
		2: v = 32'd1;
		default: v = $urandom();
		endcase
		set_config(q, m, v);
	endtask

	function automatic int pick_len();
		int r;
		r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 10);
		if (cfg_max_len < r) r = cfg_max_len;
		return r;
	endfunction

	task automatic random_file();
		int          n_rec, i, kind, len;
		logic [63:0] big;
		logic [7:0]  hi;
		logic [31:0] lo;
		n_rec = $urandom_range(0, 5);
		for (i = 0; i < n_rec; i++) begin
			kind = $urandom_range(0, 99);
			len = pick_len();
			if (kind < 72) begin
				send_record(cfg_version, 64'(len), len, FAULT_NONE, -1);
			end else if (kind < 76) begin
				send_record(cfg_version, 64'(len), len, FAULT_MAGIC, -1);
			end else if (kind < 80) begin
				send_record(cfg_version ^ (32'd1 << $urandom_range(0, 31)), 64'(len), len,
					FAULT_NONE, -1);
			end else if (kind < 84) begin
				send_record(cfg_version, 64'(len), len, FAULT_SUM, -1);
			end else if (kind < 88) begin
				hi = 8'($urandom_range(1, 255));
				lo = $urandom();
				if (cfg_max_len < 32'd200) big = {32'd0, cfg_max_len} + 64'd1 + $urandom_range(0, 3);
				else if ($urandom_range(0, 1) == 0) big = {24'd0, hi, lo};
				else big = {32'd0, 32'hFFFF_FFE0 + $urandom_range(0, 31)};
				send_record(cfg_version, big, 0, FAULT_NONE, 16);
			end else if (kind < 94) begin
				send_record(cfg_version, 64'(len), len, FAULT_NONE, $urandom_range(1, len + 19));
				break;
			end else begin
				repeat ($urandom_range(1, 8)) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
			end
		end
		send_eof();
	endtask

	task automatic test_random_files();
		int start, files;
		start = live_words;
		files = 0;
		while (live_words - start < RANDOM_WORDS) begin
			if (files % 5 == 0) random_config();
			if (live_words - start > RANDOM_WORDS * 17 / 20) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			random_file();
			files++;
		end
	endtask

	initial begin
		cfg_quota = 32'hFFFF_FFFF;
		cfg_max_len = 32'hFFFF_FFFF;
		cfg_version = 32'd1;
		scan_rearm();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clean_file();
		test_bad_tail();
		test_halts();
		test_register_extremes();
		test_backpressure();
		test_random_files();
		drain();
		if (mismatches == 0) $display("record_log_scan_validator test passed");
		else $display("record_log_scan_validator test failed");
		$finish;
	end

endmodule
